// ===== hdl/lckr_pkg.sv =====
// Shared types and constants for the line command keyword receiver.
// Holds the queue item, scan phase, link state and keyword tables.
// Used by lckr_front, lckr_queue, lckr_back and the top level.
`default_nettype none

package lckr_pkg;

	// Byte classes made by the front end
	typedef enum logic [2:0] {
		KIND_CLEAR = 3'd0,
		KIND_CR    = 3'd1,
		KIND_LF    = 3'd2,
		KIND_NUL   = 3'd3,
		KIND_COMMA = 3'd4,
		KIND_TEXT  = 3'd5
	} kind_t;

	// One classified item as it travels through the queue
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
	} item_t;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		LINK_INIT   = 3'd0,
		LINK_READY  = 3'd1,
		LINK_FINISH = 3'd2,
		LINK_BUSY   = 3'd3,
		LINK_ERROR  = 3'd4
	} link_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_READY  = 3'd1,
		CMD_NEW    = 3'd2,
		CMD_FINISH = 3'd3,
		CMD_BUSY   = 3'd4,
		CMD_ERROR  = 3'd5
	} cmd_t;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	localparam int NUM_KW     = 5;
	localparam int KW_MAX_LEN = 6;
	localparam int KW_NEW_IDX = 1;

	localparam logic [4:0] ALL_CANDIDATES = 5'h1F;
	localparam logic [2:0] TOK_POS_MAX    = 3'd7;

	localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:KW_MAX_LEN-1] = '{
		'{"R", "E", "A", "D", "Y", CHAR_NUL},
		'{"N", "E", "W", CHAR_NUL, CHAR_NUL, CHAR_NUL},
		'{"F", "I", "N", "I", "S", "H"},
		'{"B", "U", "S", "Y", CHAR_NUL, CHAR_NUL},
		'{"E", "R", "R", "O", "R", CHAR_NUL}
	};
	localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{3'd5, 3'd3, 3'd6, 3'd4, 3'd5};
	localparam link_t KW_LINK [0:NUM_KW-1] =
		'{LINK_READY, LINK_INIT, LINK_FINISH, LINK_BUSY, LINK_ERROR};

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

endpackage

`default_nettype wire

// ===== hdl/lckr_front.sv =====
// Front end: accepts stream items and classifies each byte.
// Folds lowercase letters to uppercase. Depends on lckr_pkg.
`default_nettype none

module lckr_front import lckr_pkg::*; (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic        s_tuser,  // [0] req_type
	input  wire logic        q_full,
	output logic             q_push,
	output item_t            q_item
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.ch = s_tdata;
		if (s_tuser) begin
			q_item.kind = KIND_CLEAR;
		end else if (s_tdata == CHAR_CR) begin
			q_item.kind = KIND_CR;
		end else if (s_tdata == CHAR_LF) begin
			q_item.kind = KIND_LF;
		end else if (s_tdata == CHAR_NUL) begin
			q_item.kind = KIND_NUL;
		end else if (s_tdata == CHAR_COMMA) begin
			q_item.kind = KIND_COMMA;
		end else begin
			q_item.kind = KIND_TEXT;
			// fold a-z to A-Z
			if (s_tdata >= CHAR_LO_A && s_tdata <= CHAR_LO_Z) begin
				q_item.ch = s_tdata - CASE_DIFF;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lckr_queue.sv =====
// Short queue of classified items between front and back.
// Register array with read and write pointers. Depends on lckr_pkg.
`default_nettype none

module lckr_queue import lckr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head_item,
	output logic       full,
	output logic       empty
);

	item_t                   entry_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lckr_back.sv =====
// Back end: runs the line scan and keyword match, holds link state and flags.
// Drives the result register of the master side. Depends on lckr_pkg.
`default_nettype none

module lckr_back import lckr_pkg::*; #(
	parameter int MAX_LINE = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire item_t        q_item,
	output logic              q_pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,  // [2:0] link_state, [3] ready_seen, [4] new_seen,
	                                    // [5] finish_seen, [6] busy_seen, [7] error_seen,
	                                    // [10:8] line_command, [15:11] zero
	output logic              m_tlast   // line_ended
);

	localparam int LEN_W = $clog2(MAX_LINE);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE - 1);

	logic [LEN_W-1:0] len_q,   len_d;
	phase_t           phase_q, phase_d;
	logic [2:0]       pos_q,   pos_d;
	logic [4:0]       cand_q,  cand_d;
	link_t            link_q,  link_d;
	logic [4:0]       flags_q, flags_d;
	logic             ended_d;
	cmd_t             cmd_d;

	logic             out_valid_q;
	logic [15:0]      out_data_q;
	logic             out_last_q;

	// Pop when the result register is free or being drained
	assign q_pop    = !q_empty && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		logic found;
		len_d   = len_q;
		phase_d = phase_q;
		pos_d   = pos_q;
		cand_d  = cand_q;
		link_d  = link_q;
		flags_d = flags_q;
		ended_d = 1'b0;
		cmd_d   = CMD_NONE;
		found   = 1'b0;
		case (q_item.kind)
			KIND_CLEAR: begin
				flags_d = '0;
			end
			KIND_CR: begin
			end
			KIND_LF: begin
				if (len_q != '0) begin
					ended_d = 1'b1;
					if (phase_q != PH_LEAD && pos_q != '0) begin
						for (int k = 0; k < NUM_KW; k++) begin
							if (!found && cand_q[k] && KW_LEN[k] == pos_q) begin
								found      = 1'b1;
								cmd_d      = cmd_t'(3'(k + 1));
								flags_d[k] = 1'b1;
								if (k != KW_NEW_IDX) begin
									link_d = KW_LINK[k];
								end
							end
						end
					end
				end
				len_d   = '0;
				phase_d = PH_LEAD;
				pos_d   = '0;
				cand_d  = ALL_CANDIDATES;
			end
			KIND_NUL, KIND_COMMA, KIND_TEXT: begin
				if (len_q < LEN_LIMIT) begin
					len_d = len_q + 1'b1;
					if (phase_q != PH_DONE) begin
						if (q_item.kind == KIND_NUL) begin
							phase_d = PH_DONE;
						end else if (q_item.kind == KIND_COMMA) begin
							if (phase_q == PH_TOKEN) begin
								phase_d = PH_DONE;
							end
						end else begin
							phase_d = PH_TOKEN;
							// drop keywords that cannot match at this position
							for (int k = 0; k < NUM_KW; k++) begin
								if (pos_q >= KW_LEN[k]) begin
									cand_d[k] = 1'b0;
								end else if (KW_TEXT[k][pos_q] != q_item.ch) begin
									cand_d[k] = 1'b0;
								end
							end
							if (pos_q != TOK_POS_MAX) begin
								pos_d = pos_q + 1'b1;
							end
						end
					end
				end else begin
					// overflow: drop the byte and restart the line
					len_d   = '0;
					phase_d = PH_LEAD;
					pos_d   = '0;
					cand_d  = ALL_CANDIDATES;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			phase_q     <= PH_LEAD;
			pos_q       <= '0;
			cand_q      <= ALL_CANDIDATES;
			link_q      <= LINK_INIT;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				len_q   <= len_d;
				phase_q <= phase_d;
				pos_q   <= pos_d;
				cand_q  <= cand_d;
				link_q  <= link_d;
				flags_q <= flags_d;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= {5'b0, cmd_d, flags_d, link_d};
			out_last_q <= ended_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/line_command_keyword_receiver.sv =====
// Line command keyword receiver: top level.
// Depends on lckr_pkg, lckr_front, lckr_queue and lckr_back.
//
// Usage:
//   Slave side takes one transfer per received item: s_tdata carries the
//   UART byte, s_tuser selects a clear request (1) or a byte (0).
//   Master side returns exactly one transfer per accepted item, in order:
//   link state, the five sticky keyword flags and the ended line's keyword
//   in m_tdata, and m_tlast high when the item ended a non-empty line.
// Throughput: one item per cycle sustained while m_tready is high. The front
//   end classifies the byte and writes a four-entry queue; the back end pops
//   one entry a cycle into the result register.
// Path: an accepted item is written into a queue entry, then popped into
//   the result register behind any items queued ahead of it.
// Stalls: while m_tready is low the result register holds and the queue
//   fills; s_tready drops only when all four entries are taken.
// Reset: arst_n low clears the queue, the line scan, the link state and all
//   flags, and drops m_tvalid. No clearing pass is needed afterwards.
`default_nettype none

module line_command_keyword_receiver import lckr_pkg::*; #(
	parameter int MAX_LINE = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] rx_byte
	input  wire logic         s_tuser,  // [0] req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,  // [2:0] link_state, [3] ready_seen, [4] new_seen,
	                                    // [5] finish_seen, [6] busy_seen, [7] error_seen,
	                                    // [10:8] line_command, [15:11] zero
	output logic              m_tlast   // line_ended
);

	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	item_t push_item;
	item_t head_item;

	// Classify and push accepted items
	lckr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// Decouple front and back so each can stall on its own
	lckr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Scan lines, match keywords and hold the result register
	lckr_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== tb/lckr_result_check.sv =====
// Result check for the line command keyword receiver testbench.
// Watches both stream channels, tracks the keyword scan for every accepted
// transfer and compares each result transfer; uses the lckr_pkg codes.
`timescale 1ns / 100ps

module lckr_result_check import lckr_pkg::*; #(
	parameter int LINE_LIMIT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tlast,
	output int               mismatch_count,
	output int               status_backlog
);

	localparam logic [7:0] ASCII_NUL   = 8'h00;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_COMMA = 8'h2C;
	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam logic [7:0] LOWER_Z     = 8'h7A;
	localparam logic [7:0] CASE_SHIFT  = 8'h20;
	localparam int         WORD_COUNT  = 5;

	typedef struct {
		link_t      link;
		logic [4:0] flags;
		logic       ended;
		cmd_t       cmd;
	} line_status_t;

	// Scan state of the line being received
	logic [6:0] stored_len;
	phase_t     scan_ph;
	logic [2:0] tok_len;
	logic [4:0] still_possible;
	link_t      link_now;
	logic [4:0] seen_flags;

	line_status_t status_q[$];

	function automatic logic [47:0] keyword_text(input int k);
		case (k)
			0: keyword_text = "READY";
			1: keyword_text = "NEW";
			2: keyword_text = "FINISH";
			3: keyword_text = "BUSY";
			default: keyword_text = "ERROR";
		endcase
	endfunction

	function automatic int keyword_len(input int k);
		case (k)
			0: keyword_len = 5;
			1: keyword_len = 3;
			2: keyword_len = 6;
			3: keyword_len = 4;
			default: keyword_len = 5;
		endcase
	endfunction

	function automatic cmd_t keyword_cmd(input int k);
		case (k)
			0: keyword_cmd = CMD_READY;
			1: keyword_cmd = CMD_NEW;
			2: keyword_cmd = CMD_FINISH;
			3: keyword_cmd = CMD_BUSY;
			default: keyword_cmd = CMD_ERROR;
		endcase
	endfunction

	function automatic link_t keyword_link(input int k);
		case (k)
			0: keyword_link = LINK_READY;
			2: keyword_link = LINK_FINISH;
			3: keyword_link = LINK_BUSY;
			4: keyword_link = LINK_ERROR;
			default: keyword_link = LINK_INIT;
		endcase
	endfunction

	task automatic restart_line();
		stored_len = '0;
		scan_ph = PH_LEAD;
		tok_len = '0;
		still_possible = '1;
	endtask

	// Drop every keyword that no longer fits the token seen so far
	task automatic match_token_char(input logic [7:0] ch);
		logic [7:0]  up;
		logic [47:0] text;
		int          k;
		int          len;
		up = (ch >= LOWER_A && ch <= LOWER_Z) ? ch - CASE_SHIFT : ch;
		for (k = 0; k < WORD_COUNT; k++) begin
			len = keyword_len(k);
			text = keyword_text(k);
			if (int'(tok_len) >= len) begin
				still_possible[k] = 1'b0;
			end else if (text[8 * (len - 1 - int'(tok_len)) +: 8] != up) begin
				still_possible[k] = 1'b0;
			end
		end
		if (tok_len != 3'd7)
			tok_len = tok_len + 3'd1;
	endtask

	task automatic scan_char(input logic [7:0] ch);
		if (scan_ph == PH_DONE)
			return;
		if (ch == ASCII_NUL) begin
			scan_ph = PH_DONE;
		end else if (ch == ASCII_COMMA) begin
			if (scan_ph == PH_TOKEN)
				scan_ph = PH_DONE;
		end else begin
			scan_ph = PH_TOKEN;
			match_token_char(ch);
		end
	endtask

	// First surviving keyword of exactly the token length wins
	task automatic close_line(output cmd_t cmd);
		int k;
		cmd = CMD_NONE;
		if (scan_ph == PH_LEAD || tok_len == 0)
			return;
		for (k = 0; k < WORD_COUNT; k++) begin
			if (cmd == CMD_NONE && still_possible[k] && keyword_len(k) == int'(tok_len)) begin
				seen_flags[k] = 1'b1;
				cmd = keyword_cmd(k);
				if (cmd != CMD_NEW)
					link_now = keyword_link(k);
			end
		end
	endtask

	task automatic track_item(input logic clear_req, input logic [7:0] ch,
			output line_status_t st);
		st.ended = 1'b0;
		st.cmd = CMD_NONE;
		if (clear_req) begin
			seen_flags = '0;
		end else if (ch == ASCII_CR) begin
			// carriage return leaves everything as it is
		end else if (ch == ASCII_LF) begin
			if (stored_len != 0) begin
				st.ended = 1'b1;
				close_line(st.cmd);
			end
			restart_line();
		end else if (int'(stored_len) < LINE_LIMIT - 1) begin
			stored_len = stored_len + 7'd1;
			scan_char(ch);
		end else begin
			restart_line();
		end
		st.link = link_now;
		st.flags = seen_flags;
	endtask

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
		mismatch_count = mismatch_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_status_t want;
		line_status_t fresh;
		int k;
		if (!arst_n) begin
			restart_line();
			link_now = LINK_INIT;
			seen_flags = '0;
			status_q.delete();
			mismatch_count = 0;
			status_backlog <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					report("result transfer with nothing pending", m_tdata, 16'd0);
				end else begin
					want = status_q.pop_front();
					if (m_tdata[2:0] !== want.link)
						report("link_state", 16'(m_tdata[2:0]), 16'(want.link));
					for (k = 0; k < WORD_COUNT; k++) begin
						if (m_tdata[3 + k] !== want.flags[k])
							report($sformatf("sticky flag %0d", k), 16'(m_tdata[3 + k]),
								16'(want.flags[k]));
					end
					if (m_tdata[10:8] !== want.cmd)
						report("line_command", 16'(m_tdata[10:8]), 16'(want.cmd));
					if (m_tdata[15:11] !== 5'd0)
						report("tdata padding", 16'(m_tdata[15:11]), 16'd0);
					if (m_tlast !== want.ended)
						report("line_ended", 16'(m_tlast), 16'(want.ended));
				end
			end
			if (s_tvalid && s_tready) begin
				track_item(s_tuser, s_tdata, fresh);
				status_q.push_back(fresh);
			end
			status_backlog <= status_q.size();
		end
	end

endmodule

// ===== tb/line_command_keyword_receiver_test.sv =====
// Top of the line command keyword receiver testbench: clock, reset, stimulus
// and verdict. Depends on line_command_keyword_receiver and lckr_result_check.
`timescale 1ns / 100ps

module line_command_keyword_receiver_test;

	localparam int         LINE_LIMIT   = 64;
	localparam int         ITEM_GOAL    = 1700;
	localparam int         PAUSE_EVERY  = 400;
	localparam int         DRAIN_CYCLES = 8;
	localparam logic [7:0] ASCII_NUL    = 8'h00;
	localparam logic [7:0] ASCII_LF     = 8'h0A;
	localparam logic [7:0] ASCII_CR     = 8'h0D;
	localparam logic [7:0] ASCII_COMMA  = 8'h2C;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [2:0] link, [7:3] sticky flags, [10:8] command, [15:11] zero
	logic        m_tlast;   // line_ended

	int          mismatch_count;
	int          status_backlog;
	bit          steady_run;   // no idling on either side while set
	int          sent_count;   // accepted transfers, carriage returns not counted
	logic [7:0]  line_bytes[$];

	line_command_keyword_receiver #(
		.MAX_LINE(LINE_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	lckr_result_check #(
		.LINE_LIMIT(LINE_LIMIT)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.mismatch_count(mismatch_count),
		.status_backlog(status_backlog)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Receiver side: stall at random with a chance of 8 in 100, never during the steady stretch
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= steady_run || ($urandom_range(99) >= 8);
	end

	// Hard stop: far beyond the slowest correct run
	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic string keyword_name(input int k);
		case (k)
			0: keyword_name = "READY";
			1: keyword_name = "NEW";
			2: keyword_name = "FINISH";
			3: keyword_name = "BUSY";
			default: keyword_name = "ERROR";
		endcase
	endfunction

	// Offer one transfer, sometimes after a random idle stretch, and hold it until taken
	task automatic send_item(input logic clear_req, input logic [7:0] ch);
		while (!steady_run && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= clear_req;
		s_tdata <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (clear_req || ch != ASCII_CR)
			sent_count++;
	endtask

	task automatic send_line();
		while (line_bytes.size() != 0)
			send_item(1'b0, line_bytes.pop_front());
	endtask

	task automatic add_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++)
			line_bytes.push_back(txt[i]);
	endtask

	// Stop offering and wait until every result is back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (status_backlog != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] ch;
		ch = 8'($urandom_range(8'h5A, 8'h41));
		if ($urandom_range(1))
			ch = ch + 8'h20;
		return ch;
	endfunction

	// Keyword line: optional leading commas, keyword in mixed case, sometimes
	// bent out of shape, then optional arguments or a NUL tail, optional CR, then LF
	task automatic add_keyword_line();
		string      word;
		int         lead;
		int         len;
		int         bend;
		int         bend_pos;
		int         tail;
		int         i;
		logic [7:0] ch;
		lead = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
		repeat (lead)
			line_bytes.push_back(ASCII_COMMA);
		word = keyword_name($urandom_range(4));
		len = word.len();
		bend = $urandom_range(9);
		bend_pos = $urandom_range(len - 1);
		if (bend == 0)
			len = len - 1;
		for (i = 0; i < len; i++) begin
			ch = (bend == 1 && i == bend_pos) ? random_letter() : word[i];
			if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(1))
				ch = ch + 8'h20;
			// stray carriage returns must not disturb the match
			if ($urandom_range(19) == 0)
				line_bytes.push_back(ASCII_CR);
			line_bytes.push_back(ch);
		end
		if (bend == 2) begin
			repeat ($urandom_range(3, 1))
				line_bytes.push_back(random_letter());
		end
		tail = $urandom_range(3);
		if (tail == 1 || tail == 3)
			line_bytes.push_back(ASCII_COMMA);
		if (tail == 1) begin
			repeat ($urandom_range(8))
				line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
		end else if (tail == 2) begin
			line_bytes.push_back(ASCII_NUL);
			repeat ($urandom_range(4))
				line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
		end
		if ($urandom_range(1))
			line_bytes.push_back(ASCII_CR);
		line_bytes.push_back(ASCII_LF);
	endtask

	initial begin
		int pick;
		int next_pause;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = 8'h00;
		steady_run = 1'b0;
		sent_count = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed: plain keyword, leading comma with lowercase and CR,
		// empty line, clear request, NUL before the token, top byte value,
		// line of only a comma
		add_text("READY");
		line_bytes.push_back(ASCII_LF);
		send_line();
		line_bytes.push_back(ASCII_COMMA);
		add_text("new");
		line_bytes.push_back(ASCII_CR);
		line_bytes.push_back(ASCII_LF);
		send_line();
		line_bytes.push_back(ASCII_LF);
		send_line();
		send_item(1'b1, 8'hFF);
		line_bytes.push_back(ASCII_NUL);
		add_text("busy");
		line_bytes.push_back(ASCII_LF);
		send_line();
		line_bytes.push_back(8'hFF);
		line_bytes.push_back(ASCII_LF);
		send_line();
		line_bytes.push_back(ASCII_COMMA);
		line_bytes.push_back(ASCII_LF);
		send_line();
		hold_until_drained();

		// Random lines, mostly well-formed keyword lines
		next_pause = PAUSE_EVERY;
		while (sent_count < ITEM_GOAL) begin
			steady_run = (sent_count >= 800 && sent_count < 1100);
			pick = $urandom_range(99);
			if (pick < 65) begin
				add_keyword_line();
			end else if (pick < 80) begin
				// noise: any byte value, embedded LFs split the line
				repeat ($urandom_range(12))
					line_bytes.push_back(8'($urandom_range(255)));
				line_bytes.push_back(ASCII_LF);
			end else if (pick < 86) begin
				// filler around the line limit, then a keyword line so the
				// restarted tail gets matched
				repeat ($urandom_range(LINE_LIMIT + 2, LINE_LIMIT - 3))
					line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
				add_keyword_line();
			end else if (pick < 93) begin
				repeat ($urandom_range(3))
					line_bytes.push_back(ASCII_COMMA);
				line_bytes.push_back(ASCII_LF);
			end else begin
				send_item(1'b1, 8'($urandom_range(255)));
			end
			send_line();
			if (sent_count >= next_pause) begin
				hold_until_drained();
				next_pause = next_pause + PAUSE_EVERY;
			end
		end
		steady_run = 1'b0;

		hold_until_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && status_backlog == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
